// ===== rtl/pfra_pkg.sv =====
// Shared types, constants and codes of the page frame reference count allocator.
package pfra_pkg;

    // Default sizing of the frame table.
    localparam int unsigned FRAME_COUNT_DEF = 3840;
    localparam int unsigned LOW_BASE_DEF    = 1048576;
    localparam int unsigned USED_MARK_DEF   = 100;

    // Field widths.
    localparam int unsigned OP_W       = 3;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned CFG_W      = 25;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned RES_ADDR_W = 24;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned ST_W       = 2;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned SPAN_W     = CFG_W - PAGE_SHIFT;

    localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hffff_f000;

    // Request codes.
    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
    localparam logic [OP_W-1:0] OP_SHARE = 3'd3;
    localparam logic [OP_W-1:0] OP_COW   = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM      = 2'd1;
    localparam logic [ST_W-1:0] ST_BELOW    = 2'd2;
    localparam logic [ST_W-1:0] ST_NONEXIST = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_END   = 1'b1;
    localparam logic [CFG_W-1:0]     START_RESET   = 25'h010_0000;
    localparam logic [CFG_W-1:0]     END_RESET     = 25'h100_0000;

    // Operations of the shared count unit.
    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_INC,
        ALU_DEC,
        ALU_ONE
    } t_alu_op;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             is_zero;
        logic             is_one;
    } t_alu_res;

endpackage

// ===== rtl/pfra_count_ram.sv =====
// Single-port-write, single-port-read count memory with registered read data.
module pfra_count_ram #(
    parameter int unsigned DEPTH = pfra_pkg::FRAME_COUNT_DEF,
    parameter int unsigned IDX_W = $clog2(pfra_pkg::FRAME_COUNT_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [IDX_W-1:0]           i_waddr,
    input  logic [pfra_pkg::CNT_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]           i_raddr,
    output logic [pfra_pkg::CNT_W-1:0] o_rdata
);
    import pfra_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pfra_count_alu.sv =====
// Shared count unit: pass-through, saturating increment and decrement, set to one, zero and one tests.
module pfra_count_alu (
    input  pfra_pkg::t_alu_op          i_op,
    input  logic [pfra_pkg::CNT_W-1:0] i_count,
    output pfra_pkg::t_alu_res         o_res
);
    import pfra_pkg::*;

    logic [CNT_W-1:0] nxt;

    always_comb begin
        unique case (i_op)
            ALU_PASS: nxt = i_count;
            ALU_INC:  nxt = (i_count == {CNT_W{1'b1}}) ? i_count : i_count + CNT_W'(1);
            ALU_DEC:  nxt = (i_count == '0) ? i_count : i_count - CNT_W'(1);
            ALU_ONE:  nxt = CNT_W'(1);
            default:  nxt = i_count;
        endcase
    end

    assign o_res.count   = nxt;
    assign o_res.is_zero = (i_count == '0);
    assign o_res.is_one  = (i_count == CNT_W'(1));

endmodule

// ===== rtl/page_frame_refcount_allocator.sv =====
// Top level of the page frame reference count allocator: sequencer, decode and config.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_op, i_page_address
//  out     | from block| o_out_valid / i_out_stall| o_status, o_result_address,
//          |           |                          | o_ref_count, o_make_writable
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// Free, share and query pass through decode, read-modify-write and done; a rejected address
// goes from decode straight to done. Cow on a sole owner passes decode, owner check and done.
// Alloc and cow with allocation scan the table downward from the last frame, reading one
// count per cycle through the single read port of the count memory.
// Init computes the range, then sweeps the table with one memory write per frame.
// After reset a clearing pass zeroes the table; input stalls meanwhile.
// A request is taken only when the sequencer is idle; a finished result waits in the
// output register under o_out_valid while the next request is already accepted, and the
// sequencer holds in its final state while that register is still full and stalled.
module page_frame_refcount_allocator #(
    parameter int unsigned FRAME_COUNT = pfra_pkg::FRAME_COUNT_DEF,
    parameter int unsigned LOW_BASE    = pfra_pkg::LOW_BASE_DEF,
    parameter int unsigned USED_MARK   = pfra_pkg::USED_MARK_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pfra_pkg::OP_W-1:0]       i_op,
    input  logic [pfra_pkg::ADDR_W-1:0]     i_page_address,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pfra_pkg::ST_W-1:0]       o_status,
    output logic [pfra_pkg::RES_ADDR_W-1:0] o_result_address,
    output logic [pfra_pkg::CNT_W-1:0]      o_ref_count,
    output logic                            o_make_writable,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfra_pkg::CFG_W-1:0]      i_cfg_data
);
    import pfra_pkg::*;

    localparam int unsigned IDX_W = $clog2(FRAME_COUNT);
    localparam int unsigned RNG_W = (IDX_W > SPAN_W) ? IDX_W : SPAN_W;
    localparam int unsigned PAGE_W = ADDR_W - PAGE_SHIFT;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(FRAME_COUNT - 1);
    localparam logic [ADDR_W-1:0] BASE_A   = ADDR_W'(LOW_BASE);
    localparam logic [CFG_W-1:0]  BASE_C   = CFG_W'(LOW_BASE);
    localparam logic [CNT_W-1:0]  MARK     = CNT_W'(USED_MARK);
    localparam logic [PAGE_W-1:0] FRAMES_P = PAGE_W'(FRAME_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INIT_SETUP,
        S_SWEEP,
        S_COW_CHK,
        S_SCAN,
        S_RD,
        S_RMW,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [OP_W-1:0]     r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [IDX_W-1:0]    r_idx;
    logic                r_tracked;
    logic [IDX_W-1:0]    r_chk;
    logic [IDX_W-1:0]    r_sweep;
    logic [CFG_W-1:0]    r_start;
    logic [SPAN_W-1:0]   r_lo;
    logic [SPAN_W-1:0]   r_n;
    logic [CFG_W-1:0]    r_mem_start;
    logic [CFG_W-1:0]    r_mem_end;
    logic [ST_W-1:0]     r_st;
    logic [RES_ADDR_W-1:0] r_ra;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_mw;
    logic                r_out_valid;
    logic [ST_W-1:0]     r_out_status;
    logic [RES_ADDR_W-1:0] r_out_addr;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_mw;

    // Address decode of the held request.
    logic [ADDR_W-1:0] eff;
    logic [ADDR_W-1:0] off;
    logic [PAGE_W-1:0] page;
    logic              below;
    logic              at_or_below;
    logic              beyond;
    logic              ge_end;
    logic              cow_tracked;
    logic [IDX_W-1:0]  dec_idx;

    // Init range and scan helpers.
    logic [CFG_W-1:0]  lo_full;
    logic [CFG_W-1:0]  n_full;
    logic [RNG_W-1:0]  sweep_w;
    logic [RNG_W-1:0]  lo_w;
    logic              in_range;
    logic [ADDR_W-1:0] found_full;

    // Memory and count unit connections.
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [CNT_W-1:0]  rd_data;
    t_alu_op           alu_op;
    t_alu_res          alu_res;

    pfra_count_ram #(
        .DEPTH (FRAME_COUNT),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    pfra_count_alu u_alu (
        .i_op    (alu_op),
        .i_count (rd_data),
        .o_res   (alu_res)
    );

    // A cow request works on the page base; the other requests use the address as given.
    assign eff         = (r_op == OP_COW) ? (r_addr & PAGE_MASK) : r_addr;
    assign below       = (eff < BASE_A);
    assign at_or_below = (eff <= BASE_A);
    assign off         = eff - BASE_A;
    assign page        = off[ADDR_W-1:PAGE_SHIFT];
    assign beyond      = (page >= FRAMES_P);
    assign ge_end      = (eff >= {{(ADDR_W - CFG_W){1'b0}}, r_mem_end});
    assign cow_tracked = !below && !beyond;
    assign dec_idx     = page[IDX_W-1:0];

    assign lo_full  = r_start - BASE_C;
    assign n_full   = r_mem_end - r_start;
    assign sweep_w  = RNG_W'(r_sweep);
    assign lo_w     = RNG_W'(r_lo);
    assign in_range = (sweep_w >= lo_w) && ((sweep_w - lo_w) < RNG_W'(r_n));

    assign found_full = BASE_A + (ADDR_W'(r_chk) << PAGE_SHIFT);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = '0;
        mem_raddr = r_idx;
        alu_op    = ALU_PASS;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdata = in_range ? '0 : MARK;
            end
            S_DECODE: begin
                if (r_op == OP_ALLOC || (r_op == OP_COW && !cow_tracked)) begin
                    mem_raddr = LAST_IDX;
                end else begin
                    mem_raddr = dec_idx;
                end
            end
            S_COW_CHK: begin
                // Prime the scan in case the page is shared.
                mem_raddr = LAST_IDX;
            end
            S_SCAN: begin
                // Read one frame ahead while the current count is tested.
                mem_raddr = (r_chk == '0) ? '0 : r_chk - IDX_W'(1);
                alu_op    = ALU_ONE;
                mem_waddr = r_chk;
                mem_wdata = alu_res.count;
                mem_we    = alu_res.is_zero;
            end
            S_RMW: begin
                mem_waddr = r_idx;
                mem_wdata = alu_res.count;
                mem_we    = (r_op != OP_QUERY);
                if (r_op == OP_SHARE) begin
                    alu_op = ALU_INC;
                end else if (r_op == OP_QUERY) begin
                    alu_op = ALU_PASS;
                end else begin
                    alu_op = ALU_DEC;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The finishing state loads the output register itself.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_sweep == LAST_IDX) begin
                        r_sweep <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_sweep <= r_sweep + IDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_addr  <= i_page_address;
                        r_st    <= ST_OK;
                        r_ra    <= '0;
                        r_cnt   <= '0;
                        r_mw    <= 1'b0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_idx <= dec_idx;
                    unique case (r_op)
                        OP_INIT: begin
                            r_start <= (r_mem_start < BASE_C) ? BASE_C : r_mem_start;
                            r_state <= S_INIT_SETUP;
                        end
                        OP_ALLOC: begin
                            r_tracked <= 1'b0;
                            r_chk     <= LAST_IDX;
                            r_state   <= S_SCAN;
                        end
                        OP_FREE: begin
                            if (below) begin
                                r_st    <= ST_BELOW;
                                r_state <= S_DONE;
                            end else if (ge_end || beyond) begin
                                r_st    <= ST_NONEXIST;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RMW;
                            end
                        end
                        OP_SHARE: begin
                            if (at_or_below) begin
                                r_st    <= ST_BELOW;
                                r_state <= S_DONE;
                            end else if (beyond) begin
                                r_st    <= ST_NONEXIST;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RMW;
                            end
                        end
                        OP_QUERY: begin
                            if (below) begin
                                r_st    <= ST_BELOW;
                                r_state <= S_DONE;
                            end else if (beyond) begin
                                r_st    <= ST_NONEXIST;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RMW;
                            end
                        end
                        OP_COW: begin
                            r_tracked <= cow_tracked;
                            if (cow_tracked) begin
                                r_state <= S_COW_CHK;
                            end else begin
                                r_chk   <= LAST_IDX;
                                r_state <= S_SCAN;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_INIT_SETUP: begin
                    r_lo    <= lo_full[CFG_W-1:PAGE_SHIFT];
                    r_n     <= (r_mem_end > r_start) ? n_full[CFG_W-1:PAGE_SHIFT] : '0;
                    r_sweep <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (r_sweep == LAST_IDX) begin
                        r_sweep <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_sweep <= r_sweep + IDX_W'(1);
                    end
                end
                S_COW_CHK: begin
                    if (alu_res.is_one) begin
                        r_mw    <= 1'b1;
                        r_cnt   <= CNT_W'(1);
                        r_state <= S_DONE;
                    end else begin
                        // Kept as the answer should no frame be free.
                        r_cnt   <= rd_data;
                        r_chk   <= LAST_IDX;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (alu_res.is_zero) begin
                        r_ra <= found_full[RES_ADDR_W-1:0];
                        if (r_op == OP_ALLOC) begin
                            r_cnt   <= CNT_W'(1);
                            r_state <= S_DONE;
                        end else if (r_tracked) begin
                            // The old frame may be the one just taken, so read it again.
                            r_state <= S_RD;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_DONE;
                        end
                    end else if (r_chk == '0) begin
                        r_st    <= ST_OOM;
                        r_state <= S_DONE;
                    end else begin
                        r_chk <= r_chk - IDX_W'(1);
                    end
                end
                S_RD: begin
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    r_cnt   <= alu_res.count;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_st;
                        r_out_addr   <= r_ra;
                        r_out_count  <= r_cnt;
                        r_out_mw     <= r_mw;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_start <= START_RESET;
            r_mem_end   <= END_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MEM_START: r_mem_start <= i_cfg_data;
                CFG_MEM_END:   r_mem_end   <= i_cfg_data;
                default:       r_mem_end   <= r_mem_end;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_address = r_out_addr;
    assign o_ref_count      = r_out_count;
    assign o_make_writable  = r_out_mw;

`ifndef SYNTH
    // A sole-owner answer never comes with an error or another count.
    a_writable_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_make_writable) |-> (o_status == ST_OK && o_ref_count == CNT_W'(1)))
        else $error("make_writable with bad status or count");

    // An exhausted table reports no frame address.
    a_oom_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OOM) |-> (o_result_address == '0))
        else $error("out of memory result carries an address");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted twice in a row");

    // A result is loaded only from the finishing state.
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) && r_state != S_DONE |=> !$rose(o_out_valid))
        else $error("result presented outside the finishing state");
`endif

endmodule
